// ----- rtl/cmv_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the mesh vertex unit.
`default_nettype none
package cmv_pkg;

  localparam int unsigned FieldW  = 32;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned CntW    = 5;
  localparam int unsigned MulW    = 34;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned AccW    = 72;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned MulLast = 12;
  localparam int unsigned FrameWords = 12;
  localparam logic signed [MulW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [FieldW-1:0] OneQ16 = 32'sd65536;

  localparam logic       ReqLoad  = 1'b0;
  localparam logic [1:0] TgtFirst = 2'd0;
  localparam logic [1:0] TgtSecond = 2'd1;
  localparam logic [1:0] TgtThird = 2'd2;
  localparam logic [1:0] TgtFrame = 2'd3;

  typedef struct packed {
    logic                     req_type;
    logic [1:0]               load_target;
    logic [IdxW-1:0]          load_index;
    logic signed [FieldW-1:0] load_value;
    logic [IdxW-1:0]          index_i;
    logic [IdxW-1:0]          index_j;
    logic [IdxW-1:0]          index_k;
  } in_word_t;

  typedef struct packed {
    logic signed [FieldW-1:0] point_x;
    logic signed [FieldW-1:0] point_y;
    logic signed [FieldW-1:0] point_z;
  } out_word_t;

  typedef struct packed {
    logic            in_fire;
    logic            init;
    logic            rot;
    logic            mul;
    logic            out_load;
    logic [CntW-1:0] cnt;
  } cmv_cmd_t;

  typedef struct packed {
    logic cyl;
  } cmv_sts_t;

  function automatic logic [29:0] atan_turn(input logic [CntW-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cmv_ctrl.sv -----
// Sequencer: table read, CORDIC and multiply (cylindrical mode only), then output.
`default_nettype none
module cmv_ctrl
  import cmv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_req_type_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire cmv_sts_t sts_i,
  output cmv_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StInit = 5'b00010,
    StRot  = 5'b00100,
    StMul  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ov_q, ov_d;
  logic            fire;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign fire        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.in_fire = fire;
    cmd_o.cnt     = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (fire && (in_req_type_i != ReqLoad)) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.cyl ? StRot : StDone;
      end
      StRot: begin
        cmd_o.rot = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          cnt_d   = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulLast)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cmv_dpath.sv -----
// Tables, frame store, CORDIC rotator, shared multiplier and accumulator.
`default_nettype none
module cmv_dpath
  import cmv_pkg::*;
#(
  parameter int unsigned MAX_BOUNDARIES = 256,
  parameter int unsigned VALUE_WIDTH    = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_word_t in_data_i,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_data_i,
  input  wire cmv_cmd_t cmd_i,
  output cmv_sts_t      sts_o,
  output out_word_t     out_data_o
);

  localparam int unsigned W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned Sh = 32 - W;
  localparam int unsigned AW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
  localparam int unsigned EW = AW + IdxW;
  localparam logic signed [AccW-1:0] SatHi = AccW'((72'sd1 <<< (W - 1)) - 72'sd1);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - 72'sd1;

  logic signed [FieldW-1:0] mem_i [MAX_BOUNDARIES];
  logic signed [FieldW-1:0] mem_j [MAX_BOUNDARIES];
  logic signed [FieldW-1:0] mem_k [MAX_BOUNDARIES];
  logic signed [FieldW-1:0] frame_q [FrameWords];
  logic signed [FieldW-1:0] rd_i_q, rd_j_q, rd_k_q;
  logic                     ok_i_q, ok_j_q, ok_k_q;
  logic                     mode_q;

  logic [EW-1:0] ld_ext, ii_ext, jj_ext, kk_ext;
  logic          ld_ok;
  logic signed [FieldW-1:0] ld_val;
  logic signed [FieldW-1:0] tv_i, tv_j, tv_k;

  assign ld_ext = EW'(in_data_i.load_index);
  assign ii_ext = EW'(in_data_i.index_i);
  assign jj_ext = EW'(in_data_i.index_j);
  assign kk_ext = EW'(in_data_i.index_k);
  assign ld_ok  = ld_ext < EW'(MAX_BOUNDARIES);
  assign ld_val = $signed(in_data_i.load_value << Sh) >>> Sh;
  assign sts_o.cyl = mode_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_fire) begin
      if (in_data_i.req_type == ReqLoad) begin
        if (ld_ok && in_data_i.load_target == TgtFirst) begin
          mem_i[ld_ext[AW-1:0]] <= ld_val;
        end
        if (ld_ok && in_data_i.load_target == TgtSecond) begin
          mem_j[ld_ext[AW-1:0]] <= ld_val;
        end
        if (ld_ok && in_data_i.load_target == TgtThird) begin
          mem_k[ld_ext[AW-1:0]] <= ld_val;
        end
      end else begin
        rd_i_q <= mem_i[ii_ext[AW-1:0]];
        rd_j_q <= mem_j[jj_ext[AW-1:0]];
        rd_k_q <= mem_k[kk_ext[AW-1:0]];
        ok_i_q <= ii_ext < EW'(MAX_BOUNDARIES);
        ok_j_q <= jj_ext < EW'(MAX_BOUNDARIES);
        ok_k_q <= kk_ext < EW'(MAX_BOUNDARIES);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int n = 0; n < FrameWords; n++) begin
        frame_q[n] <= '0;
      end
      frame_q[3]  <= OneQ16;
      frame_q[7]  <= OneQ16;
      frame_q[11] <= OneQ16;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.in_fire && in_data_i.req_type == ReqLoad &&
          in_data_i.load_target == TgtFrame &&
          in_data_i.load_index < IdxW'(FrameWords)) begin
        frame_q[in_data_i.load_index[3:0]] <= ld_val;
      end
    end
  end

  assign tv_i = ok_i_q ? rd_i_q : '0;
  assign tv_j = ok_j_q ? rd_j_q : '0;
  assign tv_k = ok_k_q ? rd_k_q : '0;

  // CORDIC rotation on the residual angle within one quadrant.
  logic [31:0] phase, phase_r, rem;
  logic [1:0]  quad, quad_q;
  logic signed [MulW-1:0] x_q, y_q, z_q, dx, dy, at, cos_v, sin_v;

  assign phase   = {tv_k[15:0], 16'h0000};
  assign phase_r = phase + 32'h2000_0000;
  assign quad    = phase_r[31:30];
  assign rem     = phase - {quad, 30'd0};
  assign dx      = y_q >>> cmd_i.cnt;
  assign dy      = x_q >>> cmd_i.cnt;
  assign at      = $signed(MulW'(atan_turn(cmd_i.cnt)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= MulW'($signed(rem));
      quad_q <= quad;
    end else if (cmd_i.rot) begin
      if (!z_q[MulW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    case (quad_q)
      2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
      2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
      2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
      default: begin cos_v = y_q;  sin_v = -x_q; end
    endcase
  end

  // One shared multiplier: r*cos, r*sin, then the nine frame products.
  logic signed [MulW-1:0]  cx_q, cy_q, cz, rr, op_a, op_b;
  logic signed [ProdW-1:0] prod_q, prod_rnd;
  logic signed [AccW-1:0]  acc_q, acc_init, acc_sh, sat_v;
  logic signed [FieldW-1:0] org;
  logic [CntW-1:0] k;
  logic signed [FieldW-1:0] res_x_q, res_y_q, res_z_q;
  out_word_t out_q;

  assign rr = MulW'(tv_i);
  assign cz = MulW'(tv_j);
  assign k  = cmd_i.cnt - 1'b1;

  always_comb begin
    op_a = cz;
    op_b = MulW'(frame_q[11]);
    case (cmd_i.cnt)
      5'd0:  begin op_a = rr;   op_b = cos_v; end
      5'd1:  begin op_a = rr;   op_b = sin_v; end
      5'd2:  begin op_a = cx_q; op_b = MulW'(frame_q[3]);  end
      5'd3:  begin op_a = cy_q; op_b = MulW'(frame_q[6]);  end
      5'd4:  begin op_a = cz;   op_b = MulW'(frame_q[9]);  end
      5'd5:  begin op_a = cx_q; op_b = MulW'(frame_q[4]);  end
      5'd6:  begin op_a = cy_q; op_b = MulW'(frame_q[7]);  end
      5'd7:  begin op_a = cz;   op_b = MulW'(frame_q[10]); end
      5'd8:  begin op_a = cx_q; op_b = MulW'(frame_q[5]);  end
      5'd9:  begin op_a = cy_q; op_b = MulW'(frame_q[8]);  end
      default: begin op_a = cz; op_b = MulW'(frame_q[11]); end
    endcase
  end

  always_comb begin
    case (k)
      5'd2:    org = frame_q[0];
      5'd5:    org = frame_q[1];
      default: org = frame_q[2];
    endcase
  end

  // The origin and the half-unit rounding term seed the accumulator.
  assign acc_init = (AccW'(org) <<< 16) + AccW'(32768);
  assign prod_rnd = (prod_q + (ProdW'(1) <<< 29)) >>> 30;
  assign acc_sh   = acc_q >>> 16;
  assign sat_v    = (acc_sh > SatHi) ? SatHi : ((acc_sh < SatLo) ? SatLo : acc_sh);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul && cmd_i.cnt <= CntW'(10)) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.mul && cmd_i.cnt != '0) begin
      case (k)
        5'd0: cx_q <= MulW'(prod_rnd);
        5'd1: cy_q <= MulW'(prod_rnd);
        5'd2, 5'd5, 5'd8: acc_q <= acc_init + AccW'(prod_q);
        5'd3, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10: acc_q <= acc_q + AccW'(prod_q);
        default: ;
      endcase
      case (cmd_i.cnt)
        5'd6:  res_x_q <= FieldW'(sat_v);
        5'd9:  res_y_q <= FieldW'(sat_v);
        5'd12: res_z_q <= FieldW'(sat_v);
        default: ;
      endcase
    end
    if (cmd_i.init && !mode_q) begin
      res_x_q <= tv_i;
      res_y_q <= tv_j;
      res_z_q <= tv_k;
    end
    if (cmd_i.out_load) begin
      out_q.point_x <= res_x_q;
      out_q.point_y <= res_y_q;
      out_q.point_z <= res_z_q;
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ----- rtl/cylindrical_mesh_vertex_to_cartesian_unit.sv -----
// Top level of the mesh vertex unit: sequencer plus datapath.
`default_nettype none
// Load words give no result and do not stall the input. A Cartesian point word
// passes the init and done states before its result is valid; a cylindrical one
// also passes the rotation and multiply states: 24 CORDIC rotation steps and the 11
// products that pass one at a time through the single shared multiplier. A
// finished word waits in the output register while the next word is taken. Tables
// read as zero past MAX_BOUNDARIES; their entries are undefined until written.
module cylindrical_mesh_vertex_to_cartesian_unit
  import cmv_pkg::*;
#(
  parameter int unsigned MAX_BOUNDARIES = 256,
  parameter int unsigned VALUE_WIDTH    = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_data_i
);

  cmv_cmd_t cmd;
  cmv_sts_t sts;

  cmv_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  cmv_dpath #(
    .MAX_BOUNDARIES (MAX_BOUNDARIES),
    .VALUE_WIDTH    (VALUE_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ----- rtl/cmv_checker.sv -----
// Port-level checks for the mesh vertex unit and their binding to the top level.
`default_nettype none
module cmv_checker
  import cmv_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_word_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type != ReqLoad |=> !in_ready_o)
    else $error("new word taken while a point is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.req_type == ReqLoad |=> in_ready_o)
    else $error("load word stalled the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result word appeared too early");

endmodule

bind cylindrical_mesh_vertex_to_cartesian_unit cmv_checker u_cmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

// ----- test/tb_cylindrical_mesh_vertex_to_cartesian_unit.sv -----
// Self-checking testbench for the mesh vertex unit: directed and random words, scoreboard.
module tb_cylindrical_mesh_vertex_to_cartesian_unit;
  import cmv_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int unsigned Depth = 256;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned LongHold = 400;
  localparam logic ReqPoint = 1'b1;
  localparam logic ModeCart = 1'b0;
  localparam logic ModeCyl = 1'b1;
  localparam longint GainQ30 = 652032874;
  localparam longint AngleTurns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;
  logic cfg_we;
  logic cfg_data;

  logic signed [31:0] radius_tbl [Depth];
  logic signed [31:0] height_tbl [Depth];
  logic signed [31:0] angle_tbl [Depth];
  logic signed [31:0] frame_words [12];
  logic coord_mode;

  out_word_t pending_points [$];
  int mismatches;
  int hold_left;
  int stall_left;
  bit no_gaps;
  int idle_cycles;

  cylindrical_mesh_vertex_to_cartesian_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic void sin_cos_q30(input logic [31:0] theta, output longint c,
                                      output longint s);
    logic [31:0] phase;
    logic [31:0] resid;
    logic [1:0] quad;
    longint x, y, z, dx, dy;
    phase = {theta[15:0], 16'h0000};
    quad = 2'((phase + 32'h2000_0000) >> 30);
    resid = phase - {quad, 30'd0};
    z = longint'($signed(resid));
    x = GainQ30;
    y = 0;
    for (int n = 0; n < 24; n++) begin
      dx = y >>> n;
      dy = x >>> n;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AngleTurns[n];
      end else begin
        x += dx;
        y -= dy;
        z += AngleTurns[n];
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] frame_axis(input wide_t cx, input wide_t cy,
                                                    input wide_t cz, input int col);
    wide_t acc;
    acc = cx * wide_t'(frame_words[3 + col]) + cy * wide_t'(frame_words[6 + col])
          + cz * wide_t'(frame_words[9 + col]);
    acc = ((acc + 32768) >>> 16) + wide_t'(frame_words[col]);
    if (acc > wide_t'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (acc < -wide_t'(32'sh7fff_ffff) - 1) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function automatic void apply_word(input in_word_t w);
    out_word_t p;
    longint c, s;
    wide_t cx, cy;
    if (w.req_type == ReqLoad) begin
      case (w.load_target)
        TgtFirst: radius_tbl[w.load_index] = w.load_value;
        TgtSecond: height_tbl[w.load_index] = w.load_value;
        TgtThird: angle_tbl[w.load_index] = w.load_value;
        default: if (w.load_index < 12) frame_words[w.load_index[3:0]] = w.load_value;
      endcase
      return;
    end
    p.point_x = radius_tbl[w.index_i];
    p.point_y = height_tbl[w.index_j];
    p.point_z = angle_tbl[w.index_k];
    if (coord_mode == ModeCyl) begin
      sin_cos_q30(angle_tbl[w.index_k], c, s);
      cx = (wide_t'(radius_tbl[w.index_i]) * wide_t'(c) + (wide_t'(1) <<< 29)) >>> 30;
      cy = (wide_t'(radius_tbl[w.index_i]) * wide_t'(s) + (wide_t'(1) <<< 29)) >>> 30;
      p.point_x = frame_axis(cx, cy, wide_t'(height_tbl[w.index_j]), 0);
      p.point_y = frame_axis(cx, cy, wide_t'(height_tbl[w.index_j]), 1);
      p.point_z = frame_axis(cx, cy, wide_t'(height_tbl[w.index_j]), 2);
    end
    pending_points.push_back(p);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected word", out_word.point_x, 32'h0);
        end else begin
          want = pending_points.pop_front();
          if (out_word.point_x !== want.point_x)
            report_mismatch("point_x", out_word.point_x, want.point_x);
          if (out_word.point_y !== want.point_y)
            report_mismatch("point_y", out_word.point_y, want.point_y);
          if (out_word.point_z !== want.point_z)
            report_mismatch("point_z", out_word.point_z, want.point_z);
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
    apply_word(w);
  endtask

  function automatic in_word_t load_word(input logic [1:0] tgt, input logic [7:0] idx,
                                         input logic [31:0] val);
    in_word_t w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    w.req_type = ReqLoad;
    w.load_target = tgt;
    w.load_index = idx;
    w.load_value = val;
    return w;
  endfunction

  function automatic in_word_t point_word(input logic [7:0] i, input logic [7:0] j,
                                          input logic [7:0] k);
    in_word_t w;
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    w.req_type = ReqPoint;
    w.index_i = i;
    w.index_j = j;
    w.index_k = k;
    return w;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    coord_mode = m;
  endtask

  task automatic test_fill_tables();
    no_gaps = 1'b1;
    for (int n = 0; n < Depth; n++) begin
      send_word(load_word(TgtFirst, 8'(n), $urandom));
      send_word(load_word(TgtSecond, 8'(n), $urandom));
      send_word(load_word(TgtThird, 8'(n), $urandom));
    end
    no_gaps = 1'b0;
    send_word(load_word(TgtFirst, 8'd0, 32'sh8000_0000));
    send_word(load_word(TgtFirst, 8'd255, 32'sh7fff_ffff));
    send_word(load_word(TgtSecond, 8'd0, 32'sh7fff_ffff));
    send_word(load_word(TgtSecond, 8'd255, 32'sh8000_0000));
    send_word(load_word(TgtThird, 8'd0, 32'h0000_0000));
    send_word(load_word(TgtThird, 8'd255, 32'hffff_ffff));
  endtask

  task automatic test_cartesian();
    send_word(point_word(8'd0, 8'd0, 8'd0));
    send_word(point_word(8'd255, 8'd255, 8'd255));
    send_word(point_word(8'd0, 8'd255, 8'd128));
    send_word(load_word(TgtFrame, 8'd12, 32'h1234_5678));
    send_word(load_word(TgtFrame, 8'd255, 32'h8765_4321));
  endtask

  task automatic test_angles();
    logic [31:0] angles [10] = '{32'h0, 32'h4000, 32'h8000, 32'hc000, 32'h2000,
                                 32'he000, 32'h1fff, 32'h6000, 32'h0001_5555,
                                 32'hffff_ffff};
    for (int n = 0; n < 10; n++) begin
      send_word(load_word(TgtThird, 8'(10 + n), angles[n]));
      send_word(point_word(8'd255, 8'd5, 8'(10 + n)));
    end
    send_word(point_word(8'd0, 8'd255, 8'd10));
  endtask

  task automatic test_frame_saturation();
    for (int n = 0; n < 12; n++)
      send_word(load_word(TgtFrame, 8'(n), n[0] ? 32'sh7fff_ffff : 32'sh8000_0000));
    send_word(point_word(8'd255, 8'd0, 8'd10));
    send_word(point_word(8'd0, 8'd255, 8'd12));
    send_word(load_word(TgtFrame, 8'd0, 32'h0));
    send_word(load_word(TgtFrame, 8'd1, 32'h0));
    send_word(load_word(TgtFrame, 8'd2, 32'h0));
    send_word(point_word(8'd255, 8'd255, 8'd11));
  endtask

  task automatic test_random(input int count);
    logic [31:0] v;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        v = $urandom;
        if ($urandom_range(0, 3) != 0) v = $signed(v) >>> $urandom_range(8, 15);
        send_word(load_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 3) == 0 ?
                            $urandom_range(0, 15) : $urandom_range(0, 255)), v));
      end else begin
        send_word(point_word(8'($urandom), 8'($urandom), 8'($urandom)));
      end
      if ($urandom_range(0, 199) == 0) no_gaps = ~no_gaps;
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk_i);
    hold_left = LongHold;
    for (int n = 0; n < 20; n++)
      send_word(point_word(8'($urandom), 8'($urandom), 8'($urandom)));
    wait_drained();
    for (int n = 0; n < 10; n++)
      send_word(point_word(8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    mismatches = 0;
    hold_left = 0;
    stall_left = 0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    coord_mode = ModeCart;
    for (int n = 0; n < 12; n++) frame_words[n] = 32'sh0;
    frame_words[3] = OneQ16;
    frame_words[7] = OneQ16;
    frame_words[11] = OneQ16;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_tables();
    test_cartesian();
    set_mode(ModeCyl);
    test_angles();
    test_frame_saturation();
    test_random(300);
    test_backpressure();
    set_mode(ModeCart);
    test_random(250);
    set_mode(ModeCyl);
    test_random(350);
    set_mode(ModeCart);
    test_random(150);
    set_mode(ModeCyl);
    test_random(100);
    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cmv_pkg.sv
rtl/cmv_ctrl.sv
rtl/cmv_dpath.sv
rtl/cylindrical_mesh_vertex_to_cartesian_unit.sv
rtl/cmv_checker.sv
test/tb_cylindrical_mesh_vertex_to_cartesian_unit.sv
